@@ hw/rtl/acc_pkg.sv @@
// acc_pkg: shared constants, types and helpers for the clustering coefficient block
// no dependencies
package acc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned FracBits = 16;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned CoefW    = FracBits + 1;
  localparam int unsigned DegW     = CntW;
  localparam int unsigned DenW     = 2 * DegW;
  // pair sum bounded by deg*deg
  localparam int unsigned PairW    = 2 * DegW;
  localparam int unsigned NumW     = PairW + FracBits;
  localparam int unsigned SumW     = CoefW + CntW;

  typedef enum logic [2:0] {
    ST_LOAD, ST_ROWRD, ST_ROWWT, ST_NBR, ST_DIV, ST_AVG, ST_OUT
  } acc_state_e;

  // division request and result between sequencer and divider
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [NumW-1:0] den;
  } acc_div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } acc_div_rsp_t;

  function automatic logic [DegW-1:0] popcnt(input logic [MaxNodes-1:0] v);
    logic [DegW-1:0] c;
    c = '0;
    for (int k = 0; k < MaxNodes; k++) c = c + DegW'(v[k]);
    return c;
  endfunction

endpackage

@@ hw/rtl/acc_if.sv @@
// acc_if: valid/ready channel carrying one payload word
// depends on nothing; payload type given by parameter
interface acc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/acc_div.sv @@
// acc_div: restoring divider, one quotient bit per cycle
// depends on acc_pkg
module acc_div import acc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  acc_div_req_t req_i,
  output acc_div_rsp_t rsp_o
);
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [NumW:0]    trial;

  // one shift-subtract step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[NumW]) begin
        rem_d = trial[NumW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule

@@ hw/rtl/avg_clustering_coefficient.sv @@
// channel   dir  payload                         accepted when
// in_ch     in   neighbor_mask[64], last_row     valid && ready
// out_ch    out  coefficient[17], nodes_seen[7]  valid && ready
//
// rows load one per cycle, while the block is loading, into a row memory with
// one write and one read port. after the last row, each node takes a row read
// and a wait state, then one read per neighbor, then a divide when it has links;
// the average takes another divide and then goes into the output register.
// reset is asynchronous; no clearing pass. input stalls only while a graph is
// computed; a finished word waits in the output register while the next graph
// loads, and the next word waits until the previous one is taken.
//
// top level; depends on acc_pkg, acc_if, acc_div
module avg_clustering_coefficient import acc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  acc_if.sink   in_ch,
  acc_if.source out_ch
);
  logic [MaxNodes-1:0] mem_q [MaxNodes];
  logic [MaxNodes-1:0] rd_q;
  logic                mem_we;
  logic [IdxW-1:0]     wr_addr, rd_addr;

  acc_state_e          st_q, st_d;
  logic [CntW-1:0]     cnt_q, cnt_d, n_q, n_d;
  logic [IdxW-1:0]     node_q, node_d, rdj_q, rdj_d;
  logic [MaxNodes-1:0] row_q, row_d, valid_q, valid_d, todo_q, todo_d;
  logic [PairW-1:0]    pair_q, pair_d;
  logic [DegW-1:0]     deg_q, deg_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [CoefW-1:0]    coef_q, coef_d;
  logic [CntW-1:0]     nodes_q, nodes_d;
  logic                ovld_q, ovld_d;
  logic                acc_pend_q;
  logic                last_node;
  acc_div_req_t        dreq;
  acc_div_rsp_t        drsp;
  logic [MaxNodes-1:0] self_m, cur_m, rest_m, lowbit;
  logic [DenW-1:0]     den;
  logic [PairW-1:0]    lnk2;
  logic [CntW-1:0]     valid_n;
  logic [PairW-1:0]    pair_fix;

  // row memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= in_ch.data.neighbor_mask;
    rd_q <= mem_q[rd_addr];
  end
  assign wr_addr = cnt_q[IdxW-1:0];

  acc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign in_ch.ready = (st_q == ST_LOAD);
  assign mem_we      = in_ch.valid && in_ch.ready && (cnt_q < CntW'(MaxNodes));
  assign last_node   = (CntW'(node_q) + CntW'(1)) == n_q;

  // remaining neighbors of the current node, lowest first
  assign rest_m = todo_q;
  assign lowbit = rest_m & (~rest_m + MaxNodes'(1));
  assign self_m = MaxNodes'(1) << node_q;
  assign cur_m  = rd_q & valid_q & ~self_m;
  assign den    = DenW'(deg_q) * DenW'(deg_q - DegW'(1));
  assign lnk2   = {pair_q[PairW-1:1], 1'b0};
  assign valid_n = cnt_d;

  // common neighbors with the neighbor whose row is in rd_q
  assign pair_fix = pair_q + PairW'(popcnt(row_q & rd_q & valid_q & ~(MaxNodes'(1) << rdj_q)));

  always_comb begin
    rd_addr = node_q;
    if (st_q == ST_NBR) begin
      for (int k = MaxNodes - 1; k >= 0; k--) if (lowbit[k]) rd_addr = IdxW'(k);
    end
  end

  // sequencer
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    node_d  = node_q;
    rdj_d   = rdj_q;
    row_d   = row_q;
    valid_d = valid_q;
    todo_d  = todo_q;
    pair_d  = pair_q;
    deg_d   = deg_q;
    sum_d   = sum_q;
    coef_d  = coef_q;
    nodes_d = nodes_q;
    ovld_d  = ovld_q;
    dreq    = '0;
    if (out_ch.valid && out_ch.ready) ovld_d = 1'b0;
    unique case (st_q)
      ST_LOAD: begin
        if (in_ch.valid && in_ch.ready) begin
          if (mem_we) cnt_d = cnt_q + CntW'(1);
          if (in_ch.data.last_row) begin
            n_d     = cnt_d;
            valid_d = (valid_n >= CntW'(MaxNodes)) ? '1
                    : ((MaxNodes'(1) << valid_n) - MaxNodes'(1));
            node_d  = '0;
            sum_d   = '0;
            st_d    = ST_ROWRD;
          end
        end
      end
      ST_ROWRD: st_d = ST_ROWWT;
      ST_ROWWT: begin
        row_d  = cur_m;
        todo_d = cur_m;
        deg_d  = popcnt(cur_m);
        pair_d = '0;
        st_d   = ST_NBR;
      end
      ST_NBR: begin
        // fold in the neighbor row read on the previous cycle
        if (acc_pend_q) pair_d = pair_fix;
        if (rest_m != '0) begin
          // read of lowest remaining neighbor issued this cycle
          todo_d = rest_m & ~lowbit;
          rdj_d  = rd_addr;
        end else if (!acc_pend_q) begin
          st_d = ST_DIV;
          if (pair_q[PairW-1:1] != '0 && deg_q >= DegW'(2)) begin
            dreq.start = 1'b1;
            dreq.num   = NumW'(lnk2) << FracBits;
            dreq.den   = NumW'(den);
          end else begin
            st_d = last_node ? ST_AVG : ST_ROWRD;
            node_d = node_q + IdxW'(1);
            if (last_node) begin
              dreq.start = 1'b1;
              dreq.num   = NumW'(sum_q);
              dreq.den   = NumW'(n_q);
            end
          end
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          sum_d  = sum_q + SumW'(drsp.quot);
          node_d = node_q + IdxW'(1);
          if (last_node) begin
            dreq.start = 1'b1;
            dreq.num   = NumW'(sum_d);
            dreq.den   = NumW'(n_q);
            st_d = ST_AVG;
          end else begin
            st_d = ST_ROWRD;
          end
        end
      end
      ST_AVG: begin
        if (drsp.done) st_d = ST_OUT;
      end
      ST_OUT: begin
        // quotient holds in the divider until the output register is free
        if (!ovld_q) begin
          ovld_d  = 1'b1;
          coef_d  = CoefW'(drsp.quot);
          nodes_d = n_q;
          cnt_d   = '0;
          st_d    = ST_LOAD;
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_LOAD;
      cnt_q      <= '0;
      ovld_q     <= 1'b0;
      acc_pend_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      ovld_q     <= ovld_d;
      acc_pend_q <= (st_q == ST_NBR) && (rest_m != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    node_q  <= node_d;
    rdj_q   <= rdj_d;
    row_q   <= row_d;
    valid_q <= valid_d;
    todo_q  <= todo_d;
    pair_q  <= pair_d;
    deg_q   <= deg_d;
    sum_q   <= sum_d;
    coef_q  <= coef_d;
    nodes_q <= nodes_d;
  end

  assign out_ch.valid            = ovld_q;
  assign out_ch.data.coefficient = coef_q;
  assign out_ch.data.nodes_seen  = nodes_q;
endmodule
